/* src/slf_pkg.sv */
// Package for the scheduled light with linear fade.
// Holds the shared constants, register codes, state types and the window configuration struct.
// No dependencies.
package slf_pkg;

	localparam logic [7:0]  FULL_LEVEL     = 8'd255;
	localparam logic [15:0] MS_PER_MINUTE  = 16'd60000;
	localparam logic [10:0] MIN_PER_HOUR   = 11'd60;
	localparam logic [15:0] FADE_MIN_RESET = 16'd30;

	localparam int unsigned TOD_W  = 11;
	localparam int unsigned ADDR_W = 5;

	typedef enum logic [2:0] {
		REG_ON_HOUR,
		REG_ON_MINUTE,
		REG_OFF_HOUR,
		REG_OFF_MINUTE,
		REG_FADE_MINUTES
	} slf_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WIN,
		ST_PREP,
		ST_DIV,
		ST_DONE
	} slf_state_t;

	typedef enum logic [1:0] {
		DV_IDLE,
		DV_LOAD,
		DV_STEP
	} slf_div_state_t;

	typedef struct packed {
		logic [4:0] on_hour;
		logic [5:0] on_minute;
		logic [4:0] off_hour;
		logic [5:0] off_minute;
	} slf_win_cfg_t;

	function automatic logic [TOD_W-1:0] minute_of_day(input logic [4:0] hour,
			input logic [5:0] minute);
		logic [TOD_W-1:0] h;
		h = TOD_W'(hour);
		return TOD_W'(h * MIN_PER_HOUR) + TOD_W'(minute);
	endfunction

endpackage

/* src/slf_window.sv */
// On-window test for the scheduled light.
// Compares the minute of day against the on and off times, with wrap past midnight.
// Depends on slf_pkg.
module slf_window import slf_pkg::*; (
	input  logic [4:0]   hour,
	input  logic [5:0]   minute,
	input  slf_win_cfg_t cfg,
	output logic         in_win
);

	logic [TOD_W-1:0] t;
	logic [TOD_W-1:0] t_on;
	logic [TOD_W-1:0] t_off;

	always_comb begin
		t     = minute_of_day(hour, minute);
		t_on  = minute_of_day(cfg.on_hour, cfg.on_minute);
		t_off = minute_of_day(cfg.off_hour, cfg.off_minute);
		// Equal on and off times mean no schedule at all.
		if (t_on == t_off) begin
			in_win = 1'b0;
		end else if (t_on < t_off) begin
			in_win = (t >= t_on) && (t < t_off);
		end else begin
			in_win = (t >= t_on) || (t < t_off);
		end
	end

endmodule

/* src/slf_div.sv */
// Restoring divider that forms floor(elapsed * 255 / dur) one quotient bit per cycle.
// The caller guarantees elapsed < dur, so the quotient fits in eight bits.
// Depends on slf_pkg.
module slf_div import slf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] elapsed,
	input  logic [31:0] dur,
	output logic        done,
	output logic [7:0]  quo
);

	slf_div_state_t state_q, state_d;

	logic [39:0] num_q;
	logic [31:0] rem_q;
	logic [7:0]  quo_q;
	logic [2:0]  cnt_q;
	logic        done_q;
	logic [33:0] diff;
	logic        ge;

	// One shared subtractor serves as compare and subtract for every quotient bit.
	assign diff = {1'b0, rem_q, num_q[7]} - {2'b00, dur};
	assign ge   = ~diff[33];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= 3'd0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == DV_STEP) && (cnt_q == 3'd0);
			if (state_q == DV_LOAD) begin
				cnt_q <= 3'd7;
			end else if (state_q == DV_STEP) begin
				cnt_q <= cnt_q - 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			DV_IDLE: begin
				if (start) begin
					// elapsed * 255 taken as elapsed * 256 - elapsed.
					num_q <= {elapsed, 8'h00} - {8'h00, elapsed};
				end
			end
			DV_LOAD: begin
				rem_q <= num_q[39:8];
				quo_q <= 8'h00;
			end
			DV_STEP: begin
				if (ge) begin
					rem_q <= diff[31:0];
				end else begin
					rem_q <= {rem_q[30:0], num_q[7]};
				end
				quo_q       <= {quo_q[6:0], ge};
				num_q[7:0]  <= {num_q[6:0], 1'b0};
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			DV_IDLE: if (start) state_d = DV_LOAD;
			DV_LOAD: state_d = DV_STEP;
			DV_STEP: if (cnt_q == 3'd0) state_d = DV_IDLE;
			default: state_d = DV_IDLE;
		endcase
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

/* src/scheduled_light_with_linear_fade.sv */
// Scheduled light with linear fade-out: top level.
// Holds the register file, the tick sequencer and the output register.
// Depends on slf_pkg, slf_window and slf_div.
//
// Usage: each tick transfer on the input channel (in_valid, in_stall) carries the hour,
// the minute and a free-running millisecond count; each tick produces exactly one result
// transfer on the output channel (out_valid, out_stall) with level, lamp_on and fading.
// Registers are written over the APB port at byte addresses 0, 4, 8, 12 and 16
// (on_hour, on_minute, off_hour, off_minute, fade_minutes); pready is always high.
//
// Processing: the sequencer registers the window test in ST_WIN, updates the lamp state in
// ST_PREP, runs the divider in ST_DIV only when the fade level is computed, and loads the
// output register from ST_DONE. The fade level comes from a bit-serial divider that forms
// elapsed * 255, loads it and then produces one quotient bit per cycle.
// in_stall is high while a tick is being worked on.
//
// Reset clears the lamp state (dark, no fade, level 0) and sets fade_minutes to 30.
// A result held by out_stall stays in the output register; the next tick is accepted
// and processed meanwhile, and waits in the sequencer only until that register frees up.
module scheduled_light_with_linear_fade import slf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [4:0]        clock_hour,
	input  logic [5:0]        clock_minute,
	input  logic [31:0]       now_ms,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        level,
	output logic              lamp_on,
	output logic              fading
);

	slf_state_t   state_q, state_d;
	slf_win_cfg_t win_cfg_q;
	logic [15:0]  fade_minutes_q;
	logic [31:0]  dur_q;

	logic [4:0]   hour_q;
	logic [5:0]   minute_q;
	logic [31:0]  now_q;
	logic         win_q;
	logic         in_win;

	logic         lit_q;
	logic         fade_q;
	logic [31:0]  start_q;
	logic [7:0]   level_q;

	logic         out_valid_q;
	logic [7:0]   level_out_q;
	logic         lamp_on_out_q;
	logic         fading_out_q;

	logic [31:0]  elapsed;
	logic         div_start;
	logic         div_done;
	logic [7:0]   div_quo;
	logic         load_out;
	logic         cfg_wr;
	slf_reg_t     reg_idx;

	// Register file.
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = slf_reg_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_cfg_q      <= '0;
			fade_minutes_q <= FADE_MIN_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_ON_HOUR:      win_cfg_q.on_hour    <= pwdata[4:0];
				REG_ON_MINUTE:    win_cfg_q.on_minute  <= pwdata[5:0];
				REG_OFF_HOUR:     win_cfg_q.off_hour   <= pwdata[4:0];
				REG_OFF_MINUTE:   win_cfg_q.off_minute <= pwdata[5:0];
				REG_FADE_MINUTES: fade_minutes_q       <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_ON_HOUR:      prdata = 32'(win_cfg_q.on_hour);
			REG_ON_MINUTE:    prdata = 32'(win_cfg_q.on_minute);
			REG_OFF_HOUR:     prdata = 32'(win_cfg_q.off_hour);
			REG_OFF_MINUTE:   prdata = 32'(win_cfg_q.off_minute);
			REG_FADE_MINUTES: prdata = 32'(fade_minutes_q);
			default:          prdata = 32'h0;
		endcase
	end

	// The fade duration is kept as a registered product; it is not frozen while a tick runs.
	always_ff @(posedge clk) begin
		dur_q <= {16'h0000, fade_minutes_q} * {16'h0000, MS_PER_MINUTE};
	end

	slf_window u_window (
		.hour   (hour_q),
		.minute (minute_q),
		.cfg    (win_cfg_q),
		.in_win (in_win)
	);

	// A fade that starts on this tick has zero elapsed time.
	assign elapsed = now_q - (fade_q ? start_q : now_q);

	slf_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.elapsed (elapsed),
		.dur     (dur_q),
		.done    (div_done),
		.quo     (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_WIN;
			ST_WIN:  state_d = ST_PREP;
			ST_PREP: begin
				if (!win_q && lit_q && (elapsed < dur_q)) begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DIV:  if (div_done) state_d = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && in_valid) begin
			hour_q   <= clock_hour;
			minute_q <= clock_minute;
			now_q    <= now_ms;
		end
		if (state_q == ST_WIN) begin
			win_q <= in_win;
		end
	end

	// Lamp state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lit_q   <= 1'b0;
			fade_q  <= 1'b0;
			start_q <= 32'h0;
			level_q <= 8'h00;
		end else if (state_q == ST_PREP) begin
			if (win_q) begin
				// Inside the window a running fade is frozen as it stands.
				if (!lit_q) begin
					lit_q  <= 1'b1;
					fade_q <= 1'b0;
				end
				if (!lit_q || !fade_q) begin
					level_q <= FULL_LEVEL;
				end
			end else if (lit_q) begin
				if (elapsed >= dur_q) begin
					lit_q   <= 1'b0;
					fade_q  <= 1'b0;
					level_q <= 8'h00;
				end else if (!fade_q) begin
					fade_q <= 1'b1;
				end
				if (!fade_q) begin
					start_q <= now_q;
				end
			end
		end else if ((state_q == ST_DIV) && div_done) begin
			level_q <= FULL_LEVEL - div_quo;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			level_out_q   <= level_q;
			lamp_on_out_q <= lit_q;
			fading_out_q  <= fade_q;
		end
	end

	assign out_valid = out_valid_q;
	assign level     = level_out_q;
	assign lamp_on   = lamp_on_out_q;
	assign fading    = fading_out_q;

endmodule

/* src/slf_checker.sv */
// Port-level checks for the scheduled light with linear fade.
// Bound to the top level; sees only its ports.
// Depends on slf_pkg and scheduled_light_with_linear_fade.
module slf_checker import slf_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [7:0]  level,
	input logic        lamp_on,
	input logic        fading
);

	// A held result keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(level) && $stable(lamp_on)
			&& $stable(fading))
		else $error("stalled result changed");

	// A fade is only ever in progress on a lit lamp.
	a_fade_lit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!fading || lamp_on))
		else $error("fading reported while lamp is off");

	// Dark means level zero; lit without a fade means full brightness.
	a_level_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (lamp_on || (level == 8'h00))
			&& (!lamp_on || fading || (level == FULL_LEVEL)))
		else $error("level does not match lamp state");

	// Each tick occupies the block for at least the cycle after its transfer.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("block ready right after a tick transfer");

endmodule

bind scheduled_light_with_linear_fade slf_checker u_slf_checker (.*);
